// File: hw/rtl/lzwc_pkg.sv
// Shared types and constants for the LZW compressor.
package lzwc_pkg;

    localparam int CODE_WIDTH_DEF = 12;
    localparam int DICT_SIZE_DEF  = 4096;
    localparam int LIMIT_W        = 13;
    localparam int FIRST_CODE     = 256;
    localparam logic [LIMIT_W-1:0] DICT_LIMIT_RST = 13'd4096;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [3:0] valid_bits;
        logic       last_out;
    } out_beat_t;

    typedef struct packed {
        logic push;
        logic flush;
    } pk_req_t;

endpackage

// File: hw/rtl/lzwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH] = '{default: '0};

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/lzwc_packer.sv
// Bit packer that turns fixed-width codes into MSB-first output bytes.
module lzwc_packer #(
    parameter int CODE_WIDTH = lzwc_pkg::CODE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lzwc_pkg::pk_req_t      req,
    input  logic [CODE_WIDTH-1:0]  code,
    output logic                   push_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output lzwc_pkg::out_beat_t    m_data
);

    localparam int BW    = CODE_WIDTH + 7;
    localparam int CNT_W = $clog2(CODE_WIDTH + 8);

    logic [BW-1:0]       buf_reg, buf_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                fin_reg, fin_next;
    logic                m_valid_reg, m_valid_next;
    lzwc_pkg::out_beat_t m_data_reg, m_data_next;
    logic                slot_free;
    logic [BW-1:0]       shifted;

    assign push_ready = (cnt_reg < CNT_W'(8)) && !fin_reg;
    assign slot_free  = !m_valid_reg || m_ready;
    assign shifted    = buf_reg >> (cnt_reg - CNT_W'(8));
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    always_comb begin
        buf_next     = buf_reg;
        cnt_next     = cnt_reg;
        fin_next     = fin_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (req.push) begin
            buf_next = BW'({buf_reg, code});
            cnt_next = cnt_reg + CNT_W'(CODE_WIDTH);
            fin_next = req.flush;
        end else if (slot_free) begin
            if (cnt_reg >= CNT_W'(8)) begin
                m_valid_next           = 1'b1;
                m_data_next.out_byte   = shifted[7:0];
                m_data_next.valid_bits = 4'd8;
                m_data_next.last_out   = fin_reg && (cnt_reg == CNT_W'(8));
                cnt_next               = cnt_reg - CNT_W'(8);
                if (cnt_reg == CNT_W'(8)) begin
                    fin_next = 1'b0;
                end
            end else if (fin_reg && (cnt_reg != '0)) begin
                m_valid_next           = 1'b1;
                m_data_next.out_byte   = buf_reg[7:0] << (CNT_W'(8) - cnt_reg);
                m_data_next.valid_bits = 4'(cnt_reg);
                m_data_next.last_out   = 1'b1;
                cnt_next               = '0;
                fin_next               = 1'b0;
            end else begin
                fin_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            fin_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            fin_reg     <= fin_next;
            m_valid_reg <= m_valid_next;
        end
        buf_reg    <= buf_next;
        m_data_reg <= m_data_next;
    end

    a_push_not_during_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_reg |-> !req.push) else $error("code pushed while a flush is pending");

    a_partial_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.valid_bits != 4'd8)) |-> m_data_reg.last_out)
        else $error("partial byte not marked as last");

endmodule

// File: hw/rtl/lzwc_ctrl.sv
// Dictionary sequencer: hashed lookup and insert over the slot and entry memories.
module lzwc_ctrl #(
    parameter int CODE_WIDTH = lzwc_pkg::CODE_WIDTH_DEF,
    parameter int DICT_SIZE  = lzwc_pkg::DICT_SIZE_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [lzwc_pkg::LIMIT_W-1:0] dict_limit,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  lzwc_pkg::in_beat_t           s_data,
    output lzwc_pkg::pk_req_t            req,
    output logic [CODE_WIDTH-1:0]        code,
    input  logic                         push_ready
);

    localparam int DW      = $clog2(DICT_SIZE);
    localparam int HW      = DW + 1;
    localparam int NCW     = CODE_WIDTH + 1;
    localparam int ENTRY_W = CODE_WIDTH + 8 + HW;
    localparam int CMP_A   = (NCW > lzwc_pkg::LIMIT_W) ? NCW : lzwc_pkg::LIMIT_W;
    localparam int CMP_W   = (CMP_A > DW + 1) ? CMP_A : DW + 1;
    localparam logic [CMP_W-1:0] DICT_SIZE_C  = CMP_W'(DICT_SIZE);
    localparam logic [CMP_W-1:0] CODE_SPACE_C = CMP_W'(2 ** CODE_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_DICT,
        ST_PUSH,
        ST_FLUSH
    } state_t;

    state_t                state_reg, state_next;
    logic [CODE_WIDTH-1:0] prefix_reg, prefix_next;
    logic                  pvalid_reg, pvalid_next;
    logic [NCW-1:0]        next_code_reg, next_code_nx;
    logic [7:0]            byte_reg, byte_next;
    logic                  last_reg, last_next;
    logic [HW-1:0]         slot_reg, slot_next;
    logic [CODE_WIDTH-1:0] cand_reg, cand_next;
    logic [CODE_WIDTH-1:0] pcode_reg, pcode_next;

    logic [HW-1:0]         hash_in;
    logic [HW-1:0]         h_raddr;
    logic [CODE_WIDTH-1:0] h_rdata;
    logic                  h_we;
    logic [ENTRY_W-1:0]    d_rdata;
    logic                  d_we;
    logic [ENTRY_W-1:0]    d_wdata;
    logic [CODE_WIDTH-1:0] e_prefix;
    logic [7:0]            e_byte;
    logic [HW-1:0]         e_slot;
    logic                  slot_used;
    logic                  hit;
    logic                  ins_ok;
    logic [CMP_W-1:0]      nc_cmp;

    assign hash_in  = HW'(prefix_reg) ^ (HW'(s_data.data_byte) << (HW - 8));
    assign h_raddr  = (state_reg == ST_DICT) ? slot_reg + HW'(1) : hash_in;
    assign e_prefix = d_rdata[ENTRY_W-1 -: CODE_WIDTH];
    assign e_byte   = d_rdata[HW+7:HW];
    assign e_slot   = d_rdata[HW-1:0];

    // A slot counts as used only if its code was allocated in this stream and points back.
    assign slot_used = (NCW'(cand_reg) >= NCW'(lzwc_pkg::FIRST_CODE))
                    && (NCW'(cand_reg) < next_code_reg) && (e_slot == slot_reg);
    assign hit       = slot_used && (e_prefix == prefix_reg) && (e_byte == byte_reg);
    assign nc_cmp    = CMP_W'(next_code_reg);
    assign ins_ok    = (nc_cmp < CMP_W'(dict_limit)) && (nc_cmp < DICT_SIZE_C)
                    && (nc_cmp < CODE_SPACE_C);

    assign h_we    = (state_reg == ST_DICT) && !slot_used && ins_ok;
    assign d_we    = h_we;
    assign d_wdata = {prefix_reg, byte_reg, slot_reg};

    lzwc_ram #(.WIDTH(CODE_WIDTH), .DEPTH(2 ** HW)) u_slots (
        .aclk  (aclk),
        .we    (h_we),
        .waddr (slot_reg),
        .wdata (CODE_WIDTH'(next_code_reg)),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    lzwc_ram #(.WIDTH(ENTRY_W), .DEPTH(DICT_SIZE)) u_entries (
        .aclk  (aclk),
        .we    (d_we),
        .waddr (DW'(next_code_reg)),
        .wdata (d_wdata),
        .raddr (DW'(h_rdata)),
        .rdata (d_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign req.push  = push_ready && ((state_reg == ST_PUSH) || (state_reg == ST_FLUSH));
    assign req.flush = (state_reg == ST_FLUSH);
    assign code      = (state_reg == ST_FLUSH) ? prefix_reg : pcode_reg;

    always_comb begin
        state_next   = state_reg;
        prefix_next  = prefix_reg;
        pvalid_next  = pvalid_reg;
        next_code_nx = next_code_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        slot_next    = slot_reg;
        cand_next    = cand_reg;
        pcode_next   = pcode_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    byte_next = s_data.data_byte;
                    last_next = s_data.last_in;
                    if (!pvalid_reg) begin
                        prefix_next = CODE_WIDTH'(s_data.data_byte);
                        pvalid_next = 1'b1;
                        if (s_data.last_in) begin
                            state_next = ST_FLUSH;
                        end
                    end else begin
                        slot_next  = hash_in;
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                cand_next  = h_rdata;
                state_next = ST_DICT;
            end
            ST_DICT: begin
                if (hit) begin
                    prefix_next = cand_reg;
                    state_next  = last_reg ? ST_FLUSH : ST_IDLE;
                end else if (slot_used) begin
                    slot_next  = slot_reg + HW'(1);
                    state_next = ST_HASH;
                end else begin
                    pcode_next  = prefix_reg;
                    prefix_next = CODE_WIDTH'(byte_reg);
                    if (ins_ok) begin
                        next_code_nx = next_code_reg + NCW'(1);
                    end
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (push_ready) begin
                    state_next = last_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (push_ready) begin
                    prefix_next  = '0;
                    pvalid_next  = 1'b0;
                    next_code_nx = NCW'(lzwc_pkg::FIRST_CODE);
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            prefix_reg    <= '0;
            pvalid_reg    <= 1'b0;
            next_code_reg <= NCW'(lzwc_pkg::FIRST_CODE);
        end else begin
            state_reg     <= state_next;
            prefix_reg    <= prefix_next;
            pvalid_reg    <= pvalid_next;
            next_code_reg <= next_code_nx;
        end
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        slot_reg  <= slot_next;
        cand_reg  <= cand_next;
        pcode_reg <= pcode_next;
    end

    a_push_with_room: assert property (@(posedge aclk) disable iff (!aresetn)
        req.push |-> push_ready) else $error("push issued without packer room");

    a_hit_keeps_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DICT && hit) |=> next_code_reg == $past(next_code_reg))
        else $error("next code changed on a dictionary hit");

    a_insert_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        d_we |-> (nc_cmp < DICT_SIZE_C)) else $error("entry written beyond dictionary");

endmodule

// File: hw/rtl/lzw_compressor_fixed_width_unit.sv
// Top level of the LZW compressor with fixed-width codes.
//
//   channel  direction  handshake          beat
//   s_       in         s_valid/s_ready    data_byte, last_in
//   m_       out        m_valid/m_ready    out_byte, valid_bits, last_out
//   cfg_     in         cfg_wr_en          dict_limit
//
// The first byte of a stream, if it is not last, only becomes the prefix.
// A byte whose prefix extension is found passes ST_HASH and ST_DICT, and both again per hash collision.
// A byte that misses also passes ST_PUSH, and waits there while the packer drains bytes.
// The packer sends at most one output byte per cycle.
// Reset is synchronous and active low; the dictionary memories need no clearing pass.
// A stall on m_ready holds the packer, which in turn holds the sequencer and s_ready.
module lzw_compressor_fixed_width_unit #(
    parameter int CODE_WIDTH = lzwc_pkg::CODE_WIDTH_DEF,
    parameter int DICT_SIZE  = lzwc_pkg::DICT_SIZE_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [lzwc_pkg::LIMIT_W-1:0] cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  lzwc_pkg::in_beat_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output lzwc_pkg::out_beat_t          m_data
);

    logic [lzwc_pkg::LIMIT_W-1:0] dict_limit_reg;
    lzwc_pkg::pk_req_t            req;
    logic [CODE_WIDTH-1:0]        code;
    logic                         push_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dict_limit_reg <= lzwc_pkg::DICT_LIMIT_RST;
        end else if (cfg_wr_en) begin
            dict_limit_reg <= cfg_wr_data;
        end
    end

    lzwc_ctrl #(.CODE_WIDTH(CODE_WIDTH), .DICT_SIZE(DICT_SIZE)) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .dict_limit (dict_limit_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .req        (req),
        .code       (code),
        .push_ready (push_ready)
    );

    lzwc_packer #(.CODE_WIDTH(CODE_WIDTH)) u_packer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (req),
        .code       (code),
        .push_ready (push_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// File: test/lzw_compressor_fixed_width_unit_tb.sv
// Self-checking testbench for the LZW compressor with fixed-width codes.
`timescale 1ns / 1ps

module lzw_compressor_fixed_width_unit_tb;

    localparam int CW = lzwc_pkg::CODE_WIDTH_DEF;
    localparam int DS = lzwc_pkg::DICT_SIZE_DEF;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        lzwc_pkg::in_beat_t  beat;
        int                  n;
        lzwc_pkg::out_beat_t e[4];
    } vec_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [lzwc_pkg::LIMIT_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    lzwc_pkg::in_beat_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    lzwc_pkg::out_beat_t m_data;

    lzwc_pkg::out_beat_t code_bytes_q[$];
    int errors = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    int hold_req = 0;
    int stall_cnt = 0;

    logic [CW-1:0] dict_pre[DS];
    logic [7:0] dict_chr[DS];
    int next_free;
    logic [CW-1:0] cur_prefix;
    bit have_prefix;
    logic [7:0] pend_bits;
    int pend_n;
    int limit_reg;

    lzw_compressor_fixed_width_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("lzw_compressor_fixed_width_unit_tb failed");
            $finish;
        end
    end

    function automatic void clear_stream();
        cur_prefix = '0;
        have_prefix = 1'b0;
        next_free = lzwc_pkg::FIRST_CODE;
        pend_bits = '0;
        pend_n = 0;
    endfunction

    function automatic void pack_code(logic [CW-1:0] code);
        logic [31:0] acc;
        int cnt;
        lzwc_pkg::out_beat_t o;
        acc = (32'(pend_bits) << CW) | 32'(code);
        cnt = pend_n + CW;
        while (cnt >= 8) begin
            cnt -= 8;
            o.out_byte = 8'(acc >> cnt);
            o.valid_bits = 4'd8;
            o.last_out = 1'b0;
            code_bytes_q.insert(code_bytes_q.size(), o);
        end
        pend_n = cnt;
        pend_bits = 8'(acc & ((32'd1 << cnt) - 1));
    endfunction

    function automatic void compress_byte(lzwc_pkg::in_beat_t b);
        int base_n;
        int eff;
        bit found;
        lzwc_pkg::out_beat_t o;
        base_n = code_bytes_q.size();
        eff = (limit_reg > DS) ? DS : limit_reg;
        found = 1'b0;
        if (!have_prefix) begin
            cur_prefix = CW'(b.data_byte);
            have_prefix = 1'b1;
        end else begin
            for (int c = lzwc_pkg::FIRST_CODE; c < next_free && c < DS; c++) begin
                if (!found && dict_pre[c] == cur_prefix && dict_chr[c] == b.data_byte) begin
                    cur_prefix = CW'(c);
                    found = 1'b1;
                end
            end
            if (!found) begin
                pack_code(cur_prefix);
                if (next_free < eff && next_free < DS) begin
                    dict_pre[next_free] = cur_prefix;
                    dict_chr[next_free] = b.data_byte;
                    next_free++;
                end
                cur_prefix = CW'(b.data_byte);
            end
        end
        if (b.last_in) begin
            pack_code(cur_prefix);
            if (pend_n > 0) begin
                o.out_byte = pend_bits << (8 - pend_n);
                o.valid_bits = 4'(pend_n);
                o.last_out = 1'b1;
                code_bytes_q.insert(code_bytes_q.size(), o);
            end else if (code_bytes_q.size() > base_n) begin
                code_bytes_q[code_bytes_q.size() - 1].last_out = 1'b1;
            end
            clear_stream();
        end
    endfunction

    task automatic send_beat(lzwc_pkg::in_beat_t b);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        compress_byte(b);
        s_valid <= 1'b1;
        s_data <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic idle_then_write(int value);
        s_valid <= 1'b0;
        while (code_bytes_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= lzwc_pkg::LIMIT_W'(value);
        limit_reg = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_streams(int count);
        lzwc_pkg::in_beat_t b;
        logic [7:0] alpha[4];
        int len;
        bit narrow;
        int sent;
        sent = 0;
        while (sent < count) begin
            len = $urandom_range(1, 30);
            narrow = ($urandom_range(0, 9) < 7);
            foreach (alpha[i]) alpha[i] = 8'($urandom);
            for (int i = 0; i < len; i++) begin
                b.data_byte = narrow ? alpha[$urandom_range(0, 1 + $urandom_range(0, 2))]
                                     : 8'($urandom);
                b.last_in = (i == len - 1);
                send_beat(b);
            end
            sent += len;
        end
    endtask

    always @(posedge aclk) begin
        if (hold_req > 0) begin
            stall_cnt <= hold_req;
            m_ready <= 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_cnt <= $urandom_range(0, 15);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (code_bytes_q.size() == 0) begin
                $display("%0t: unexpected beat %h/%0d/%0b", $time,
                         m_data.out_byte, m_data.valid_bits, m_data.last_out);
                errors++;
            end else begin
                if (m_data !== code_bytes_q[0]) begin
                    $display("%0t: expected %h/%0d/%0b actual %h/%0d/%0b", $time,
                             code_bytes_q[0].out_byte, code_bytes_q[0].valid_bits,
                             code_bytes_q[0].last_out, m_data.out_byte,
                             m_data.valid_bits, m_data.last_out);
                    errors++;
                end
                void'(code_bytes_q.pop_front());
            end
        end
    end

    initial begin
        vec_t vecs[$];
        vec_t v;
        int base_n;
        limit_reg = lzwc_pkg::DICT_LIMIT_RST;
        clear_stream();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        v.n = 2;
        v.beat = '{8'h41, 1'b1};
        v.e[0] = '{8'h04, 4'd8, 1'b0}; v.e[1] = '{8'h10, 4'd4, 1'b1};
        vecs.insert(vecs.size(), v);
        v.beat = '{8'hFF, 1'b1};
        v.e[0] = '{8'h0F, 4'd8, 1'b0}; v.e[1] = '{8'hF0, 4'd4, 1'b1};
        vecs.insert(vecs.size(), v);
        v.beat = '{8'h00, 1'b1};
        v.e[0] = '{8'h00, 4'd8, 1'b0}; v.e[1] = '{8'h00, 4'd4, 1'b1};
        vecs.insert(vecs.size(), v);
        v.n = -1;
        v.beat = '{8'h41, 1'b0}; vecs.insert(vecs.size(), v);
        v.beat = '{8'h42, 1'b1}; vecs.insert(vecs.size(), v);
        for (int i = 0; i < 9; i++) begin
            v.beat = '{(i % 2) ? 8'h42 : 8'h41, 1'b0}; vecs.insert(vecs.size(), v);
        end
        v.beat = '{8'h41, 1'b1}; vecs.insert(vecs.size(), v);
        for (int i = 0; i < 6; i++) begin
            v.beat = '{(i < 3) ? 8'hFF : 8'h00, i == 5}; vecs.insert(vecs.size(), v);
        end

        foreach (vecs[i]) begin
            base_n = code_bytes_q.size();
            if (vecs[i].n >= 0) begin
                compress_byte(vecs[i].beat);
                while (code_bytes_q.size() > base_n) void'(code_bytes_q.pop_back());
                for (int k = 0; k < vecs[i].n; k++) begin
                    code_bytes_q.insert(code_bytes_q.size(), vecs[i].e[k]);
                end
                s_valid <= 1'b1;
                s_data <= vecs[i].beat;
                do @(posedge aclk); while (!s_ready);
            end else begin
                send_beat(vecs[i].beat);
            end
        end

        idle_then_write(257);
        random_streams(60);
        idle_then_write(8191);
        fork
            random_streams(70);
            begin
                repeat (60) @(posedge aclk);
                hold_req = 400;
                @(posedge aclk);
                hold_req = 0;
            end
        join
        idle_then_write(300);
        random_streams(80);
        idle_then_write(0);
        random_streams(50);
        idle_then_write(4096);
        quiet = 1'b1;
        random_streams(90);
        s_valid <= 1'b0;

        while (code_bytes_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("lzw_compressor_fixed_width_unit_tb passed");
        end else begin
            $display("lzw_compressor_fixed_width_unit_tb failed");
        end
        $finish;
    end

endmodule

// File: lzw_compressor_fixed_width_unit.f
hw/rtl/lzwc_pkg.sv
hw/rtl/lzwc_ram.sv
hw/rtl/lzwc_packer.sv
hw/rtl/lzwc_ctrl.sv
hw/rtl/lzw_compressor_fixed_width_unit.sv
test/lzw_compressor_fixed_width_unit_tb.sv
